### src/acld_pkg.sv
// ============================================================================
// acld_pkg: shared types and constants of the ASCII command line decoder
// Character codes, result kinds, command numbers and the queue item type.
// ============================================================================
package acld_pkg;

    localparam logic [7:0] ASCII_AMP  = 8'h26;
    localparam logic [7:0] ASCII_HASH = 8'h23;
    localparam logic [7:0] ASCII_LF   = 8'h0A;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    localparam logic [2:0] KIND_SYSTEM  = 3'd0;
    localparam logic [2:0] KIND_CLOCK   = 3'd1;
    localparam logic [2:0] KIND_SETTING = 3'd2;
    localparam logic [2:0] KIND_PORT    = 3'd3;
    localparam logic [2:0] KIND_ROUTE   = 3'd4;
    localparam logic [2:0] KIND_CORR    = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;
    localparam logic [2:0] KIND_NOTCMD  = 3'd7;

    localparam logic [15:0] CMD_SYS_0 = 16'd1;
    localparam logic [15:0] CMD_SYS_1 = 16'd10;
    localparam logic [15:0] CMD_SYS_2 = 16'd201;
    localparam logic [15:0] CMD_SYS_3 = 16'd254;

    localparam logic [15:0] CMD_SET_0      = 16'd101;
    localparam logic [15:0] CMD_SET_BUZZER = 16'd102;
    localparam logic [15:0] CMD_SET_2      = 16'd103;
    localparam logic [15:0] CMD_SET_3      = 16'd210;
    localparam logic [15:0] CMD_SET_4      = 16'd220;
    localparam logic [15:0] CMD_SET_5      = 16'd611;
    localparam logic [15:0] CMD_SET_6      = 16'd612;
    localparam logic [15:0] CMD_SET_7      = 16'd613;
    localparam logic [15:0] CMD_SET_8      = 16'd621;
    localparam logic [15:0] CMD_SET_9      = 16'd622;
    localparam logic [15:0] CMD_SET_10     = 16'd623;

    localparam logic [15:0] CMD_CLOCK_FIRST = 16'd501;
    localparam logic [15:0] CMD_CLOCK_LAST  = 16'd507;
    localparam logic [15:0] CMD_CLOCK_YEAR  = 16'd504;
    localparam logic [15:0] CMD_PORT_FIRST  = 16'd200;
    localparam logic [15:0] CMD_PORT_LAST   = 16'd207;
    localparam logic [15:0] CMD_ROUTE_FIRST = 16'd300;
    localparam logic [15:0] CMD_ROUTE_LAST  = 16'd363;
    localparam logic [15:0] CMD_CORR_FIRST  = 16'd1110;
    localparam logic [15:0] CMD_CORR_LAST   = 16'd1113;

    localparam logic [15:0] YEAR_BASE  = 16'd2000;
    localparam logic [15:0] BUZZER_MAX = 16'd250;

    localparam logic [3:0] POS_HASH     = 4'd1;
    localparam logic [3:0] POS_CMD_LAST = 4'd6;
    localparam logic [3:0] POS_LAST     = 4'd11;

    localparam logic ADDR_CLOCK_ENABLED = 1'b0;

    typedef struct packed {
        logic [7:0] data;
        logic       is_amp;
        logic       is_nl;
    } item_t;

endpackage

### src/acld_front.sv
// ============================================================================
// acld_front: byte intake and classification
// Marks restart and newline bytes and holds all bytes in a two-entry queue.
// ============================================================================
module acld_front
    import acld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       item_valid,
    output item_t      item,
    input  logic       item_pop
);

    localparam int QD  = 2;
    localparam int QAW = $clog2(QD);

    item_t            queue_mem [QD];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             push;
    logic             pop;
    item_t            incoming;

    assign rx_ready   = count_reg != (QAW+1)'(QD);
    assign item_valid = count_reg != '0;
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = rx_valid && rx_ready;
    assign pop        = item_pop && item_valid;

    always_comb
    begin
        incoming.data   = rx_byte;
        incoming.is_amp = rx_byte == ASCII_AMP;
        incoming.is_nl  = rx_byte == ASCII_LF;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + (QAW+1)'(1);
                2'b01:   count_reg <= count_reg - (QAW+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

### src/acld_back.sv
// ============================================================================
// acld_back: receive store, line copy and command decode
// Stores bytes, copies the line on newline, scans it and builds the result.
// ============================================================================
module acld_back
    import acld_pkg::*;
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clock_enabled,
    input  logic        item_valid,
    input  item_t       item,
    output logic        item_pop,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  result_kind,
    output logic [5:0]  target_index,
    output logic [15:0] payload
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COPY  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WAIT  = 6'b010000,
        ST_DEC   = 6'b100000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [7:0]             rx_mem   [STORE_DEPTH];
    logic [7:0]             line_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] line_valid_reg;
    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          wp_base;
    logic [AW-1:0]          wp_inc;
    logic [AW-1:0]          copy_cnt_reg;
    logic [AW-1:0]          copy_last_reg;
    logic [AW-1:0]          copy_waddr_reg;
    logic                   copy_wr_reg;
    logic [7:0]             rx_rdata_reg;
    logic [3:0]             rd_idx_reg;
    logic [AW-1:0]          line_raddr;
    logic [7:0]             line_rdata_reg;
    logic                   line_vld_reg;
    logic                   proc_en_reg;
    logic [3:0]             proc_idx_reg;
    logic                   hash_reg;
    logic                   cmd_run_reg;
    logic                   val_run_reg;
    logic [15:0]            cmd_reg;
    logic [15:0]            val_reg;
    logic [7:0]             byte_q;
    logic                   is_digit;
    logic [15:0]            cmd_step;
    logic [15:0]            val_step;
    logic                   line_start;
    logic                   out_free;
    logic                   out_load;
    logic [15:0]            clk_off;
    logic [15:0]            port_off;
    logic [15:0]            route_off;
    logic [15:0]            corr_off;
    logic [7:0]             buzzer_val;
    logic [2:0]             dec_kind;
    logic [5:0]             dec_target;
    logic [15:0]            dec_payload;
    logic                   result_valid_reg;
    logic [2:0]             result_kind_reg;
    logic [5:0]             target_index_reg;
    logic [15:0]            payload_reg;

    assign item_pop   = (state_reg == ST_IDLE) && item_valid;
    assign line_start = item_pop && item.is_nl;
    assign wp_base    = item.is_amp ? '0 : wp_reg;
    assign wp_inc     = (wp_base == AW'(STORE_DEPTH - 1)) ? '0 : wp_base + AW'(1);
    assign line_raddr = AW'(rd_idx_reg);
    assign out_free   = !result_valid_reg || result_ready;
    assign out_load   = (state_reg == ST_DEC) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (line_start)
                begin
                    state_next = (wp_inc == '0) ? ST_SCAN : ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (copy_cnt_reg == copy_last_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (rd_idx_reg == POS_LAST)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: state_next = ST_DEC;
            ST_DEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wp_reg           <= '0;
            copy_cnt_reg     <= '0;
            copy_last_reg    <= '0;
            copy_wr_reg      <= 1'b0;
            copy_waddr_reg   <= '0;
            rd_idx_reg       <= POS_HASH;
            proc_en_reg      <= 1'b0;
            proc_idx_reg     <= POS_HASH;
            line_valid_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            copy_wr_reg    <= state_reg == ST_COPY;
            copy_waddr_reg <= copy_cnt_reg;
            proc_en_reg    <= state_reg == ST_SCAN;
            proc_idx_reg   <= rd_idx_reg;
            if (copy_wr_reg)
            begin
                line_valid_reg[copy_waddr_reg] <= 1'b1;
            end
            if (item_pop)
            begin
                wp_reg <= item.is_nl ? '0 : wp_inc;
            end
            if (line_start)
            begin
                copy_cnt_reg  <= '0;
                copy_last_reg <= wp_base;
                rd_idx_reg    <= POS_HASH;
            end
            else if (state_reg == ST_COPY)
            begin
                copy_cnt_reg <= copy_cnt_reg + AW'(1);
            end
            else if (state_reg == ST_SCAN)
            begin
                rd_idx_reg <= rd_idx_reg + 4'd1;
            end
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            rx_mem[wp_base] <= item.data;
        end
        rx_rdata_reg <= rx_mem[copy_cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (copy_wr_reg)
        begin
            line_mem[copy_waddr_reg] <= rx_rdata_reg;
        end
        line_rdata_reg <= line_mem[line_raddr];
        line_vld_reg   <= line_valid_reg[line_raddr];
    end

    assign byte_q   = line_vld_reg ? line_rdata_reg : 8'h00;
    assign is_digit = (byte_q >= ASCII_ZERO) && (byte_q <= ASCII_NINE);
    assign cmd_step = (cmd_reg << 3) + (cmd_reg << 1) + {12'd0, byte_q[3:0]};
    assign val_step = (val_reg << 3) + (val_reg << 1) + {12'd0, byte_q[3:0]};

    always_ff @(posedge clk)
    begin
        if (line_start)
        begin
            hash_reg    <= 1'b0;
            cmd_run_reg <= 1'b1;
            val_run_reg <= 1'b1;
            cmd_reg     <= '0;
            val_reg     <= '0;
        end
        else if (proc_en_reg)
        begin
            if (proc_idx_reg == POS_HASH)
            begin
                hash_reg <= byte_q == ASCII_HASH;
            end
            else if (proc_idx_reg <= POS_CMD_LAST)
            begin
                if (cmd_run_reg && is_digit)
                begin
                    cmd_reg <= cmd_step;
                end
                else
                begin
                    cmd_run_reg <= 1'b0;
                end
            end
            else
            begin
                if (val_run_reg && is_digit)
                begin
                    val_reg <= val_step;
                end
                else
                begin
                    val_run_reg <= 1'b0;
                end
            end
        end
    end

    assign clk_off    = cmd_reg - CMD_CLOCK_FIRST;
    assign port_off   = cmd_reg - CMD_PORT_FIRST;
    assign route_off  = cmd_reg - CMD_ROUTE_FIRST;
    assign corr_off   = cmd_reg - CMD_CORR_FIRST;
    assign buzzer_val = (val_reg > BUZZER_MAX) ? BUZZER_MAX[7:0] : val_reg[7:0];

    always_comb
    begin
        dec_kind    = KIND_UNKNOWN;
        dec_target  = '0;
        dec_payload = cmd_reg;
        if (!hash_reg)
        begin
            dec_kind    = KIND_NOTCMD;
            dec_payload = '0;
        end
        else
        begin
            unique case (cmd_reg)
                CMD_SYS_0:
                begin
                    dec_kind = KIND_SYSTEM; dec_target = 6'd0;
                end
                CMD_SYS_1:
                begin
                    dec_kind = KIND_SYSTEM; dec_target = 6'd1;
                end
                CMD_SYS_2:
                begin
                    dec_kind = KIND_SYSTEM; dec_target = 6'd2;
                end
                CMD_SYS_3:
                begin
                    dec_kind = KIND_SYSTEM; dec_target = 6'd3;
                end
                CMD_SET_0:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd0;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_BUZZER:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd1;
                    dec_payload = {8'h00, buzzer_val};
                end
                CMD_SET_2:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd2;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_3:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd3;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_4:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd4;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_5:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd5;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_6:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd6;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_7:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd7;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_8:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd8;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_9:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd9;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                CMD_SET_10:
                begin
                    dec_kind = KIND_SETTING; dec_target = 6'd10;
                    dec_payload = {8'h00, val_reg[7:0]};
                end
                default:
                begin
                    if (cmd_reg >= CMD_CLOCK_FIRST && cmd_reg <= CMD_CLOCK_LAST
                        && clock_enabled)
                    begin
                        dec_kind    = KIND_CLOCK;
                        dec_target  = clk_off[5:0];
                        dec_payload = (cmd_reg == CMD_CLOCK_YEAR) ? val_reg - YEAR_BASE
                                                                  : val_reg;
                    end
                    else if (cmd_reg >= CMD_PORT_FIRST && cmd_reg <= CMD_PORT_LAST)
                    begin
                        dec_kind    = KIND_PORT;
                        dec_target  = port_off[5:0];
                        dec_payload = {8'h00, val_reg[7:0]};
                    end
                    else if (cmd_reg >= CMD_ROUTE_FIRST && cmd_reg <= CMD_ROUTE_LAST)
                    begin
                        dec_kind    = KIND_ROUTE;
                        dec_target  = route_off[5:0];
                        dec_payload = {8'h00, val_reg[7:0]};
                    end
                    else if (cmd_reg >= CMD_CORR_FIRST && cmd_reg <= CMD_CORR_LAST)
                    begin
                        dec_kind    = KIND_CORR;
                        dec_target  = corr_off[5:0];
                        dec_payload = val_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_kind_reg  <= dec_kind;
            target_index_reg <= dec_target;
            payload_reg      <= dec_payload;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_kind_reg;
    assign target_index = target_index_reg;
    assign payload      = payload_reg;

endmodule

### src/ascii_command_line_decoder.sv
// ============================================================================
// ascii_command_line_decoder: decoder of ASCII command lines
// Collects received bytes into lines and decodes each line into one command.
// ============================================================================
// Bytes enter on the rx channel (rx_valid, rx_ready, rx_byte), one per beat.
// Each newline produces exactly one beat on the result channel (result_valid,
// result_ready, result_kind, target_index, payload); other bytes produce none.
// The clock_enabled register sits at address 0 of the APB port.
// A byte that is not a newline is written straight into the receive store, so
// plain bytes flow at one per cycle through a two-entry queue while the decoder
// is idle. For a newline that ends a line, the newline passes the queue, the line
// is copied from the receive store into the line store through its single read
// port, the copy is drained, the marker, command and value characters are read
// one at a time, the last digit is finished and the result is decoded. A line
// that wraps the receive store copies nothing.
// Bytes keep queueing during that time until the queue is full.
// Reset empties the queue and the output register, clears the write position
// and marks every line store entry as zero; clock_enabled resets to 1.
// When the receiver stalls, the result holds in the output register and the
// decoder keeps storing bytes; a following newline is copied and scanned,
// then waits with the byte flow stopped, and rx_ready falls once the queue fills.
// ============================================================================
module ascii_command_line_decoder
    import acld_pkg::*;
#(
    parameter int STORE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  result_kind,
    output logic [5:0]  target_index,
    output logic [15:0] payload,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic  clock_enabled_reg;
    logic  cfg_write;
    logic  item_valid;
    logic  item_pop;
    item_t item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_CLOCK_ENABLED);
    assign prdata    = (paddr[2] == ADDR_CLOCK_ENABLED) ? {31'd0, clock_enabled_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_enabled_reg <= 1'b1;
        end
        else if (cfg_write)
        begin
            clock_enabled_reg <= pwdata[0];
        end
    end

    acld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_byte    (rx_byte),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop)
    );

    acld_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .clock_enabled (clock_enabled_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_pop      (item_pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result_kind   (result_kind),
        .target_index  (target_index),
        .payload       (payload)
    );

    a_notcmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_NOTCMD |-> target_index == '0 && payload == '0)
        else $error("not-command result carries a target or payload");

    a_setting_byte: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_SETTING |-> payload[15:8] == '0)
        else $error("setting result carries more than one byte");

    a_clock_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_kind == KIND_CLOCK |-> target_index < 6'd7)
        else $error("clock field index out of range");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> clock_enabled_reg == $past(pwdata[0]))
        else $error("clock_enabled did not take the written value");

endmodule
